>>> rtl/hll_pkg.sv
package hll_pkg;

  localparam int MAX_PRECISION = 16;
  localparam int MIN_PRECISION = 4;
  localparam int STORE_DEPTH = 1 << MAX_PRECISION;
  localparam int ADDR_W = MAX_PRECISION;
  localparam int RANK_W = 5;
  localparam int ZQ_W = 49;
  localparam int NUM_W = 109;
  localparam int DEN_W = 79;
  localparam int DIV_STEPS = NUM_W;
  localparam int SQ_STEPS = 32;
  localparam logic [4:0] PREC_RESET = 5'd10;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] EST_MAX = (64'd1 << 50) - 64'd1;
  localparam logic [63:0] TWO_48 = 64'd1 << 48;
  localparam logic [63:0] LARGE_LO = TWO_48 / 64'd30;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_EST = 1'b1;

  localparam logic [1:0] MODE_RAW = 2'd0;
  localparam logic [1:0] MODE_SMALL = 2'd1;
  localparam logic [1:0] MODE_LARGE = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [31:0] hash_word;
  } in_item_t;

  typedef struct packed {
    logic [49:0] estimate_q16;
    logic [16:0] empty_count;
    logic [1:0]  range_mode;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_EST_WALK, ST_EST_DRAIN,
    ST_DEN0, ST_DEN1, ST_DEN2, ST_DIV, ST_RANGE, ST_NORM, ST_SQ_MUL,
    ST_SQ_UPD, ST_LN0, ST_LN1, ST_LN2, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_DEN_LO, MUL_DEN_HI, MUL_SQ, MUL_LN_LO, MUL_LN_HI
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic    cap_hash;
    logic    mem_clr;
    logic    add_rd;
    logic    add_wr;
    logic    walk_rd;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    est_init;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    div_init;
    logic    div_step;
    logic    range_eval;
    logic    norm_step;
    logic    sq_init;
    logic    sq_upd;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       walk_last;
    logic       div_last;
    logic       sq_last;
    logic       norm_done;
    logic [1:0] mode_next;
    logic       out_free;
  } dp_status_t;

endpackage

>>> rtl/hll_ram.sv
module hll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hll_datapath.sv
module hll_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic [31:0]        hash_word,
  input  hll_pkg::dp_cmd_t   cmd,
  output hll_pkg::dp_status_t st,
  input  logic               out_stall,
  output logic               out_valid,
  output hll_pkg::out_item_t out_data
);

  logic [4:0]  prec;
  logic [4:0]  p;
  logic [16:0] m;
  logic [31:0] hash_r;
  logic [15:0] idx_c, idx_r;
  logic [4:0]  rho_c, rho_r;
  logic [15:0] cnt;
  logic        walk_q;
  logic [hll_pkg::ZQ_W-1:0] zq;
  logic [16:0] vcnt;
  logic [63:0] prod;
  logic [hll_pkg::DEN_W-1:0] acc;
  logic [hll_pkg::NUM_W-1:0] num;
  logic [hll_pkg::DEN_W-1:0] rem;
  logic [63:0] e_r, e_q;
  logic [1:0]  mode_r, mode_next;
  logic [48:0] x;
  logic [5:0]  k;
  logic [30:0] y;
  logic [31:0] frac;
  logic [37:0] l;
  logic [31:0] mul_a, mul_b;
  logic [4:0]  rdata;
  logic        we;
  logic [15:0] waddr, raddr;
  logic [4:0]  wdata;
  logic        special;
  logic [12:0] an_c;
  logic [6:0]  num_sh;
  logic [29:0] ad;
  logic [hll_pkg::DEN_W:0] rem_s;
  logic        ge;
  logic [63:0] m64, small_lim;
  logic        small_c, large_c;
  logic [hll_pkg::DEN_W-1:0] shifted;
  logic [63:0] res;

  function automatic logic [4:0] lead_rank(input logic [31:0] w, input logic [4:0] pp);
    logic [5:0] r;
    logic       found;
    r = 6'd1;
    found = 1'b0;
    if (w == 32'd0) begin
      return 5'(6'd33 - {1'b0, pp});
    end
    for (int b = 31; b >= 0; b--) begin
      if (!found) begin
        if (w[b]) found = 1'b1;
        else r = r + 6'd1;
      end
    end
    return r[4:0];
  endfunction

  // clamp precision
  always_comb begin
    if (prec < 5'(hll_pkg::MIN_PRECISION)) p = 5'(hll_pkg::MIN_PRECISION);
    else if (prec > 5'(hll_pkg::MAX_PRECISION)) p = 5'(hll_pkg::MAX_PRECISION);
    else p = prec;
  end

  assign m = 17'd1 << p;
  assign idx_c = 16'(hash_r >> (6'd32 - {1'b0, p}));
  assign rho_c = lead_rank(hash_r << p, p);

  always_ff @(posedge clk) begin
    if (rst) begin
      prec <= hll_pkg::PREC_RESET;
    end else if (cfg_wr_en) begin
      prec <= cfg_wr_data;
    end
  end

  // store
  assign we = cmd.mem_clr || (cmd.add_wr && (rho_r > rdata));
  assign waddr = cmd.mem_clr ? cnt : idx_r;
  assign wdata = cmd.mem_clr ? '0 : rho_r;
  assign raddr = cmd.add_rd ? idx_c : cnt;

  hll_ram #(
    .WIDTH(hll_pkg::RANK_W),
    .DEPTH(hll_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.add_rd || cmd.walk_rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  // alpha terms
  always_comb begin
    special = (p == 5'd4) || (p == 5'd5) || (p == 5'd6);
    unique case (p)
      5'd4:    an_c = 13'd673;
      5'd5:    an_c = 13'd697;
      5'd6:    an_c = 13'd709;
      default: an_c = 13'd7213;
    endcase
    num_sh = special ? 7'd48 + 7'({p, 1'b0}) : 7'd48 + 7'(p) + 7'({p, 1'b0});
    ad = special ? 30'd1000 : 30'(30'd10000 << p) + 30'd10790;
  end

  // shared multiplier operands
  assign l = (mode_r == hll_pkg::MODE_SMALL ? {1'b0, p, 32'd0} : {6'd48, 32'd0}) - {k, frac};

  always_comb begin
    unique case (cmd.mul_op)
      hll_pkg::MUL_DEN_LO: begin mul_a = 32'(ad); mul_b = zq[31:0]; end
      hll_pkg::MUL_DEN_HI: begin mul_a = 32'(ad); mul_b = 32'(zq[48:32]); end
      hll_pkg::MUL_SQ:     begin mul_a = {1'b0, y}; mul_b = {1'b0, y}; end
      hll_pkg::MUL_LN_LO:  begin mul_a = l[31:0]; mul_b = hll_pkg::LN2_Q32; end
      hll_pkg::MUL_LN_HI:  begin mul_a = 32'(l[37:32]); mul_b = hll_pkg::LN2_Q32; end
      default:             begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider step and range selection
  assign rem_s = {rem, num[hll_pkg::NUM_W-1]};
  assign ge = rem_s >= {1'b0, acc};
  assign e_q = (num[hll_pkg::NUM_W-1:64] != '0) ? '1 : num[63:0];
  assign m64 = 64'(m);
  assign small_lim = ((m64 << 2) + m64) << 15;
  assign small_c = (e_q <= small_lim) && (vcnt != 17'd0);
  assign large_c = (e_q > hll_pkg::LARGE_LO) && (e_q < hll_pkg::TWO_48);

  always_comb begin
    if (small_c) mode_next = hll_pkg::MODE_SMALL;
    else if (large_c) mode_next = hll_pkg::MODE_LARGE;
    else mode_next = hll_pkg::MODE_RAW;
  end

  // final scaling and saturation
  assign shifted = (mode_r == hll_pkg::MODE_SMALL) ? acc >> (7'd48 - 7'(p)) : acc >> 16;
  always_comb begin
    if (mode_r == hll_pkg::MODE_RAW) begin
      res = (e_r > hll_pkg::EST_MAX) ? hll_pkg::EST_MAX : e_r;
    end else if (shifted > hll_pkg::DEN_W'(hll_pkg::EST_MAX)) begin
      res = hll_pkg::EST_MAX;
    end else begin
      res = shifted[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      walk_q <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      walk_q <= cmd.walk_rd;
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + 16'd1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_hash) hash_r <= hash_word;
    if (cmd.add_rd) begin
      idx_r <= idx_c;
      rho_r <= rho_c;
    end
    if (cmd.est_init) begin
      zq <= '0;
      vcnt <= '0;
    end else if (walk_q) begin
      zq <= zq + (hll_pkg::ZQ_W'(1) << (6'd32 - {1'b0, rdata}));
      if (rdata == '0) vcnt <= vcnt + 17'd1;
    end
    if (cmd.mul_op != hll_pkg::MUL_NONE) prod <= mul_a * mul_b;
    case (cmd.acc_op)
      hll_pkg::ACC_LOAD:   acc <= hll_pkg::DEN_W'(prod);
      hll_pkg::ACC_ADD_HI: acc <= acc + (hll_pkg::DEN_W'(prod) << 32);
      default: ;
    endcase
    if (cmd.div_init) begin
      num <= hll_pkg::NUM_W'(an_c) << num_sh;
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? hll_pkg::DEN_W'(rem_s - {1'b0, acc}) : hll_pkg::DEN_W'(rem_s);
      num <= {num[hll_pkg::NUM_W-2:0], ge};
    end
    if (cmd.range_eval) begin
      e_r <= e_q;
      mode_r <= mode_next;
      x <= small_c ? 49'(vcnt) : 49'(hll_pkg::TWO_48) - e_q[48:0];
      k <= 6'd48;
    end else if (cmd.norm_step && !x[48]) begin
      x <= x << 1;
      k <= k - 6'd1;
    end
    if (cmd.sq_init) begin
      y <= x[48:18];
      frac <= '0;
    end else if (cmd.sq_upd) begin
      y <= prod[61] ? prod[61:31] : prod[60:30];
      frac <= {frac[30:0], prod[61]};
    end
    if (cmd.out_load) begin
      out_data.estimate_q16 <= res[49:0];
      out_data.empty_count <= vcnt;
      out_data.range_mode <= mode_r;
    end
  end

  assign st.clear_last = (cnt == 16'hffff);
  assign st.walk_last = (cnt == 16'(m - 17'd1));
  assign st.div_last = (cnt == 16'(hll_pkg::DIV_STEPS - 1));
  assign st.sq_last = (cnt == 16'(hll_pkg::SQ_STEPS - 1));
  assign st.norm_done = x[48];
  assign st.mode_next = mode_next;
  assign st.out_free = !out_valid || !out_stall;

endmodule

>>> rtl/hll_ctrl.sv
module hll_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_stall,
  input  hll_pkg::dp_status_t st,
  output hll_pkg::dp_cmd_t    cmd
);

  hll_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hll_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_op = hll_pkg::MUL_NONE;
    cmd.acc_op = hll_pkg::ACC_NONE;
    in_stall = (state != hll_pkg::ST_IDLE);
    unique case (state)
      hll_pkg::ST_CLEAR: begin
        cmd.mem_clr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.clear_last) state_next = hll_pkg::ST_IDLE;
      end
      hll_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_hash = 1'b1;
          if (in_cmd == hll_pkg::CMD_ADD) begin
            state_next = hll_pkg::ST_ADD_RD;
          end else begin
            cmd.cnt_clr = 1'b1;
            cmd.est_init = 1'b1;
            state_next = hll_pkg::ST_EST_WALK;
          end
        end
      end
      hll_pkg::ST_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_next = hll_pkg::ST_ADD_WR;
      end
      hll_pkg::ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = hll_pkg::ST_IDLE;
      end
      hll_pkg::ST_EST_WALK: begin
        cmd.walk_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.walk_last) state_next = hll_pkg::ST_EST_DRAIN;
      end
      hll_pkg::ST_EST_DRAIN: state_next = hll_pkg::ST_DEN0;
      hll_pkg::ST_DEN0: begin
        cmd.mul_op = hll_pkg::MUL_DEN_LO;
        cmd.div_init = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next = hll_pkg::ST_DEN1;
      end
      hll_pkg::ST_DEN1: begin
        cmd.mul_op = hll_pkg::MUL_DEN_HI;
        cmd.acc_op = hll_pkg::ACC_LOAD;
        state_next = hll_pkg::ST_DEN2;
      end
      hll_pkg::ST_DEN2: begin
        cmd.acc_op = hll_pkg::ACC_ADD_HI;
        state_next = hll_pkg::ST_DIV;
      end
      hll_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.div_last) state_next = hll_pkg::ST_RANGE;
      end
      hll_pkg::ST_RANGE: begin
        cmd.range_eval = 1'b1;
        if (st.mode_next == hll_pkg::MODE_RAW) state_next = hll_pkg::ST_FIN;
        else state_next = hll_pkg::ST_NORM;
      end
      hll_pkg::ST_NORM: begin
        cmd.norm_step = 1'b1;
        if (st.norm_done) begin
          cmd.sq_init = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next = hll_pkg::ST_SQ_MUL;
        end
      end
      hll_pkg::ST_SQ_MUL: begin
        cmd.mul_op = hll_pkg::MUL_SQ;
        state_next = hll_pkg::ST_SQ_UPD;
      end
      hll_pkg::ST_SQ_UPD: begin
        cmd.sq_upd = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next = st.sq_last ? hll_pkg::ST_LN0 : hll_pkg::ST_SQ_MUL;
      end
      hll_pkg::ST_LN0: begin
        cmd.mul_op = hll_pkg::MUL_LN_LO;
        state_next = hll_pkg::ST_LN1;
      end
      hll_pkg::ST_LN1: begin
        cmd.mul_op = hll_pkg::MUL_LN_HI;
        cmd.acc_op = hll_pkg::ACC_LOAD;
        state_next = hll_pkg::ST_LN2;
      end
      hll_pkg::ST_LN2: begin
        cmd.acc_op = hll_pkg::ACC_ADD_HI;
        state_next = hll_pkg::ST_FIN;
      end
      hll_pkg::ST_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = hll_pkg::ST_IDLE;
        end
      end
      default: state_next = hll_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/hyperloglog_cardinality_sketch_core.sv
// add: accept, store read, conditional write-back, and only then the next item is taken; one store port pair
// estimate: the store walk (m = 2^precision reads), the 109-step divider and, with a range
//   correction, the 32 squaring steps dominate
// adds proceed while a finished estimate waits in the output register
// reset: synchronous; the rank store is cleared in a pass over all 65536 registers during which no
//   transfer is taken on the input channel; precision resets to 10
module hyperloglog_cardinality_sketch_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  hll_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hll_pkg::out_item_t out_data
);

  // control and status between sequencer and datapath
  hll_pkg::dp_cmd_t    cmd;
  hll_pkg::dp_status_t st;

  // sequencer: clear sweep, add read-modify-write, estimate walk and arithmetic steps
  hll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: rank store, accumulators, shared multiplier, divider, log unit, output register
  hll_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .hash_word   (in_data.hash_word),
    .cmd         (cmd),
    .st          (st),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  // no input transfer right after reset, the clearing pass is running
  a_clear_stall: assert property (@(posedge clk) ($past(rst) && !rst) |-> in_stall)
    else $error("input taken during store clear");

  // small-range correction only when some register is still empty
  a_small_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.range_mode == hll_pkg::MODE_SMALL) |-> out_data.empty_count != 17'd0)
    else $error("small-range result with no empty register");

  // empty count never exceeds the store depth
  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.empty_count <= 17'(hll_pkg::STORE_DEPTH))
    else $error("empty count beyond store depth");
`endif

endmodule

>>> tb/hyperloglog_cardinality_sketch_core_tb.sv
`timescale 1ns / 1ps

module hyperloglog_cardinality_sketch_core_tb;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = 5'd0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hll_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hll_pkg::out_item_t out_data;

  hyperloglog_cardinality_sketch_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the sketch: rank per register and the precision register
  bit [4:0]  rank_mem [0:hll_pkg::STORE_DEPTH-1];
  bit [4:0]  prec_shadow = hll_pkg::PREC_RESET;

  hll_pkg::in_item_t  hash_q [$];     // commands waiting to be driven
  hll_pkg::out_item_t estimate_q [$]; // predicted estimates, oldest first
  int        pushed_cnt = 0;
  int        taken_cnt = 0;
  int        errors = 0;
  logic      in_fire = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        quiet = 1'b0;   // no idling on either side in the closing phase

  function automatic int unsigned eff_prec(bit [4:0] raw);
    if (raw < hll_pkg::MIN_PRECISION) return hll_pkg::MIN_PRECISION;
    if (raw > hll_pkg::MAX_PRECISION) return hll_pkg::MAX_PRECISION;
    return int'(raw);
  endfunction

  // log2 in Q.32: integer part from the msb, fraction by repeated squaring
  function automatic bit [63:0] log2_fix(bit [63:0] v);
    int unsigned k;
    bit [63:0] y;
    bit [63:0] frac;
    k = 0;
    frac = '0;
    if (v == 0) return '0;
    while (k < 63 && (v >> (k + 1)) != 0) k++;
    y = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
    for (int i = 0; i < 32; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac[31 - i] = 1'b1;
      end
    end
    return ({32'd0, k[31:0]} << 32) | frac;
  endfunction

  function automatic bit [63:0] sat64(bit [127:0] x);
    return (x[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : x[63:0];
  endfunction

  // register update for one hash word
  function automatic void sketch_add(bit [31:0] x);
    int unsigned p;
    bit [31:0] idx;
    bit [31:0] w;
    int unsigned rho;
    p = eff_prec(prec_shadow);
    idx = x >> (32 - p);
    w = x << p;
    if (w == 0) begin
      rho = 33 - p;
    end else begin
      rho = 1;
      while (!w[31]) begin
        w = w << 1;
        rho++;
      end
    end
    if (rho > rank_mem[idx]) rank_mem[idx] = rho[4:0];
  endfunction

  // harmonic-mean estimate with small and large range corrections, Q34.16
  function automatic hll_pkg::out_item_t sketch_estimate();
    int unsigned p;
    bit [63:0]  m, zsum, empties, an, ad, e, lg;
    bit [127:0] num, den;
    bit [1:0]   mode;
    hll_pkg::out_item_t r;
    p = eff_prec(prec_shadow);
    m = 64'd1 << p;
    zsum = 0;
    empties = 0;
    mode = hll_pkg::MODE_RAW;
    for (int i = 0; i < m; i++) begin
      zsum += 64'd1 << (32 - rank_mem[i]);
      if (rank_mem[i] == 0) empties++;
    end
    if (m == 16) begin
      an = 673; ad = 1000;
    end else if (m == 32) begin
      an = 697; ad = 1000;
    end else if (m == 64) begin
      an = 709; ad = 1000;
    end else begin
      an = 7213 * m; ad = 10 * (1000 * m + 1079);
    end
    an = an * m * m;
    num = {64'd0, an} << 48;
    den = {64'd0, ad} * {64'd0, zsum};
    e = sat64(num / den);
    if (e <= ((5 * m) << 15) && empties > 0) begin
      lg = ({32'd0, p} << 32) - log2_fix(empties);
      e = sat64(({64'd0, m * lg} * {96'd0, hll_pkg::LN2_Q32}) >> 48);
      mode = hll_pkg::MODE_SMALL;
    end else if (e > hll_pkg::LARGE_LO && e < hll_pkg::TWO_48) begin
      lg = (64'd48 << 32) - log2_fix(hll_pkg::TWO_48 - e);
      e = sat64(({64'd0, lg} * {96'd0, hll_pkg::LN2_Q32}) >> 16);
      mode = hll_pkg::MODE_LARGE;
    end
    if (e > hll_pkg::EST_MAX) e = hll_pkg::EST_MAX;
    r.estimate_q16 = e[49:0];
    r.empty_count = empties[16:0];
    r.range_mode = mode;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // hash word that lands in register idx with the given rank at precision p
  function automatic bit [31:0] hash_for(int unsigned p, bit [31:0] idx, int unsigned rho);
    bit [31:0] low;
    int unsigned b;
    low = $urandom & (32'hFFFF_FFFF >> p);
    if (rho > 32 - p) begin
      low = 0;
    end else begin
      b = 32 - p - rho;
      low = (low & ((32'd1 << b) - 1)) | (32'd1 << b);
    end
    return (idx << (32 - p)) | low;
  endfunction

  task automatic push_cmd(logic cmd, logic [31:0] hw);
    hll_pkg::in_item_t it;
    it.cmd = cmd;
    it.hash_word = hw;
    hash_q.insert(hash_q.size(), it);
    pushed_cnt++;
  endtask

  // wait for all transfers and estimates, then let a pending add finish
  task automatic wait_idle();
    do @(negedge clk);
    while (taken_cnt != pushed_cnt || estimate_q.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_precision(logic [4:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly hash words aimed at a register with a chosen rank, some raw noise
  task automatic random_phase(logic [4:0] prec_raw, int n, int est_one_in);
    int unsigned p;
    write_precision(prec_raw);
    p = eff_prec(prec_raw);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, est_one_in) == 1)
        push_cmd(hll_pkg::CMD_EST, $urandom);
      else if ($urandom_range(0, 9) < 3)
        push_cmd(hll_pkg::CMD_ADD, $urandom);
      else
        push_cmd(hll_pkg::CMD_ADD, hash_for(p, $urandom_range(0, (1 << p) - 1),
                                            $urandom_range(1, 33 - p)));
    end
    push_cmd(hll_pkg::CMD_EST, $urandom);
    wait_idle();
  endtask

  // input driver: a held item stays until its transfer
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled, hold payload
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (hash_q.size() > 0) begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b1;
        in_data <= hash_q.pop_front();
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      out_gap <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: shadow updates on each transfer, estimate check in order
  always @(posedge clk) begin
    hll_pkg::out_item_t want;
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (cfg_wr_en) prec_shadow = cfg_wr_data;
      if (in_valid && !in_stall) begin
        taken_cnt++;
        if (in_data.cmd == hll_pkg::CMD_ADD) sketch_add(in_data.hash_word);
        else estimate_q.insert(estimate_q.size(), sketch_estimate());
      end
      if (out_valid && !out_stall) begin
        if (estimate_q.size() == 0) begin
          report_mismatch("unexpected estimate transfer", 64'd1, 64'd0);
        end else begin
          want = estimate_q.pop_front();
          if (out_data.estimate_q16 !== want.estimate_q16)
            report_mismatch("estimate_q16", 64'(out_data.estimate_q16),
                            64'(want.estimate_q16));
          if (out_data.empty_count !== want.empty_count)
            report_mismatch("empty_count", 64'(out_data.empty_count),
                            64'(want.empty_count));
          if (out_data.range_mode !== want.range_mode)
            report_mismatch("range_mode", 64'(out_data.range_mode),
                            64'(want.range_mode));
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: smallest sketch, empty, extreme words, then large range and raw
    write_precision(5'd4);
    push_cmd(hll_pkg::CMD_EST, 32'h0);
    push_cmd(hll_pkg::CMD_ADD, 32'hFFFF_FFFF);
    push_cmd(hll_pkg::CMD_ADD, 32'h0800_0000);
    push_cmd(hll_pkg::CMD_EST, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) push_cmd(hll_pkg::CMD_ADD, hash_for(4, i, 24));
    push_cmd(hll_pkg::CMD_EST, 32'h0);
    push_cmd(hll_pkg::CMD_ADD, 32'h0);
    wait_idle();
    write_precision(5'd4);
    for (int i = 0; i < 16; i++) push_cmd(hll_pkg::CMD_ADD, hash_for(4, i, 29));
    push_cmd(hll_pkg::CMD_EST, 32'h0);
    wait_idle();

    // random phases over precision settings, clamped ones included
    random_phase(5'd5, 150, 10);
    random_phase(5'd6, 150, 10);
    random_phase(5'd0, 150, 10);
    random_phase(5'd7, 150, 12);
    random_phase(5'd8, 150, 12);
    random_phase(5'd3, 150, 10);
    random_phase(5'd9, 150, 12);
    random_phase(5'd10, 150, 12);
    random_phase(5'd11, 150, 14);
    random_phase(5'd12, 150, 16);
    random_phase(5'd31, 60, 1000);
    random_phase(5'd16, 60, 1000);
    random_phase(5'd13, 120, 20);
    quiet = 1'b1;
    random_phase(5'd8, 100, 12);

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // generous cap on run time
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
